>>> design/att_pkg.sv
// Shared types and constants for the attacker threshold tracker.
package att_pkg;
    localparam int unsigned Trackers        = 32;
    localparam int unsigned SlotW           = $clog2(Trackers);
    localparam int unsigned EvalIntervalSec = 10;
    localparam logic [47:0] EvalIntervalMs  = 48'(EvalIntervalSec * 1000);
    localparam int unsigned QDepth          = 2;

    localparam logic [1:0] KIND_CREATE = 2'd0;
    localparam logic [1:0] KIND_CAP    = 2'd1;
    localparam logic [1:0] KIND_ESC    = 2'd2;

    localparam logic [1:0] ACT_REDIRECT        = 2'd0;
    localparam logic [1:0] ACT_REDIRECT_MIRROR = 2'd2;

    localparam logic [2:0] REG_ENABLE   = 3'd0;
    localparam logic [2:0] REG_THRESH   = 3'd1;
    localparam logic [2:0] REG_WINDOW   = 3'd2;
    localparam logic [2:0] REG_TTL      = 3'd3;
    localparam logic [2:0] REG_CAP      = 3'd4;
    localparam logic [2:0] REG_FIRSTACT = 3'd5;
    localparam logic [2:0] REG_ESCALATE = 3'd6;

    typedef struct packed {
        logic        cmd;
        logic [31:0] addr;
        logic [47:0] now_ms;
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ATTACK,
        ST_AGE,
        ST_ESC
    } back_state_t;
endpackage

>>> design/att_front.sv
// Front part: takes requests and queues them for the engine.
module att_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  att_pkg::req_t   s_req,
    output logic            q_valid,
    input  logic            q_ready,
    output att_pkg::req_t   q_req
);
    att_pkg::req_t q_mem_reg [att_pkg::QDepth];
    logic          wp_reg, rp_reg;
    logic [1:0]    cnt_reg;
    logic          push, pop;

    assign s_ready = (cnt_reg != 2'(att_pkg::QDepth));
    assign q_valid = (cnt_reg != 2'd0);
    assign q_req   = q_mem_reg[rp_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wp_reg] <= s_req;
        end
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

>>> design/att_back.sv
// Back part: tracker table, hit counting, aging and escalation.
module att_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      q_valid,
    output logic                      q_ready,
    input  att_pkg::req_t             q_req,
    input  logic                      cfg_enable,
    input  logic [15:0]               cfg_thresh,
    input  logic [15:0]               cfg_window,
    input  logic [15:0]               cfg_cap,
    input  logic [1:0]                cfg_first_action,
    input  logic                      cfg_escalate,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_kind,
    output logic [5:0]                m_slot,
    output logic [31:0]               m_addr_out,
    output logic [1:0]                m_action,
    output logic [31:0]               m_hits,
    output logic                      m_last
);
    localparam int unsigned N = att_pkg::Trackers;
    localparam int unsigned W = att_pkg::SlotW;

    logic [N-1:0] valid_reg, valid_next;
    logic [31:0]  addr_reg   [N];
    logic [47:0]  first_reg  [N];
    logic [31:0]  hits_reg   [N];
    logic [N-1:0] pol_reg;
    logic [1:0]   act_reg    [N];
    logic [15:0]  made_reg, made_next;
    logic [47:0]  last_eval_reg, last_eval_next;

    att_pkg::back_state_t state_reg, state_next;
    att_pkg::req_t        cur_reg, cur_next;
    logic [W-1:0]         idx_reg, idx_next;

    logic [1:0]  o_kind_reg, o_kind_next, o_act_reg, o_act_next;
    logic [5:0]  o_slot_reg, o_slot_next;
    logic [31:0] o_addr_reg, o_addr_next, o_hits_reg, o_hits_next;
    logic        o_last_reg, o_last_next, o_valid_reg, o_valid_next;

    logic [16:0] thr;
    logic [47:0] window_ms;
    logic [15:0] cap;
    assign thr       = (cfg_thresh == 16'd0) ? 17'd5 : {1'b0, cfg_thresh};
    assign window_ms = 48'((cfg_window == 16'd0) ? 16'd300 : cfg_window) * 48'd1000;
    assign cap       = (cfg_cap == 16'd0) ? 16'd256 : cfg_cap;

    // Parallel tag match and replacement choice over the table.
    logic [N-1:0] hit_vec;
    logic         found, have_empty;
    logic [W-1:0] hit_idx, free_idx, old_idx;
    logic [47:0]  cmp_ms [N];
    logic [W-1:0] cmp_ix [N];
    always_comb begin
        found = 1'b0; hit_idx = '0; have_empty = 1'b0; free_idx = '0;
        for (int i = 0; i < N; i++) begin
            hit_vec[i] = valid_reg[i] && (addr_reg[i] == cur_reg.addr);
            cmp_ms[i]  = first_reg[i];
            cmp_ix[i]  = W'(i);
        end
        for (int i = N - 1; i >= 0; i--) begin
            if (hit_vec[i]) begin found = 1'b1; hit_idx = W'(i); end
            if (!valid_reg[i]) begin have_empty = 1'b1; free_idx = W'(i); end
        end
        // Pairwise tree for the oldest entry; the lower index wins ties.
        for (int step = 1; step < N; step = step * 2) begin
            for (int i = 0; i + step < N; i = i + 2 * step) begin
                if (cmp_ms[i + step] < cmp_ms[i]) begin
                    cmp_ms[i] = cmp_ms[i + step];
                    cmp_ix[i] = cmp_ix[i + step];
                end
            end
        end
        old_idx = cmp_ix[0];
    end

    // Slots due for escalation, and whether any lies above the scan point.
    logic [N-1:0] esc_vec, esc_above;
    logic         esc_more;
    always_comb begin
        for (int i = 0; i < N; i++) begin
            esc_vec[i] = valid_reg[i] && pol_reg[i] &&
                         (act_reg[i] == att_pkg::ACT_REDIRECT) &&
                         ({1'b0, hits_reg[i]} >= {15'd0, thr, 1'b0});
        end
        esc_above = (esc_vec >> idx_reg) >> 1;
        esc_more  = |esc_above;
    end

    logic        tbl_we, tbl_claim, tbl_pol_we, tbl_act_we;
    logic [W-1:0] tbl_idx;
    logic [31:0] tbl_hits;
    logic [1:0]  tbl_act;

    always_comb begin
        logic [W-1:0] sel;
        logic [31:0]  h;
        logic         pol;
        logic [47:0]  age;
        state_next = state_reg; cur_next = cur_reg; idx_next = idx_reg;
        valid_next = valid_reg; made_next = made_reg; last_eval_next = last_eval_reg;
        o_kind_next = o_kind_reg; o_act_next = o_act_reg; o_slot_next = o_slot_reg;
        o_addr_next = o_addr_reg; o_hits_next = o_hits_reg; o_last_next = o_last_reg;
        o_valid_next = o_valid_reg;
        tbl_we = 1'b0; tbl_claim = 1'b0; tbl_pol_we = 1'b0; tbl_act_we = 1'b0;
        tbl_idx = idx_reg; tbl_hits = '0; tbl_act = '0;
        sel = '0; h = '0; pol = 1'b0; age = '0;
        q_ready = 1'b0;
        if (o_valid_reg && m_ready) o_valid_next = 1'b0;
        case (state_reg)
            att_pkg::ST_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    cur_next = q_req;
                    if (!q_req.cmd) begin
                        if (cfg_enable) state_next = att_pkg::ST_ATTACK;
                    end else if (last_eval_reg == 48'd0 ||
                                 (q_req.now_ms - last_eval_reg) >= att_pkg::EvalIntervalMs) begin
                        last_eval_next = q_req.now_ms;
                        idx_next = '0;
                        state_next = att_pkg::ST_AGE;
                    end
                end
            end
            att_pkg::ST_ATTACK: begin
                // Hold until the output register is free for a possible result.
                if (!o_valid_reg || m_ready) begin
                    sel = found ? hit_idx : (have_empty ? free_idx : old_idx);
                    h   = found ? hits_reg[sel] : 32'd0;
                    pol = found ? pol_reg[sel] : 1'b0;
                    if (h != 32'hFFFF_FFFF) h = h + 32'd1;
                    tbl_idx = sel; tbl_we = 1'b1; tbl_hits = h; tbl_claim = !found;
                    valid_next[sel] = 1'b1;
                    state_next = att_pkg::ST_IDLE;
                    if (!pol && h == {15'd0, thr}) begin
                        o_slot_next = 6'(sel); o_addr_next = cur_reg.addr;
                        o_hits_next = h; o_last_next = 1'b1; o_valid_next = 1'b1;
                        if (made_reg >= cap) begin
                            o_kind_next = att_pkg::KIND_CAP; o_act_next = att_pkg::ACT_REDIRECT;
                        end else begin
                            o_kind_next = att_pkg::KIND_CREATE; o_act_next = cfg_first_action;
                            tbl_pol_we = 1'b1; tbl_act_we = 1'b1; tbl_act = cfg_first_action;
                            made_next = made_reg + 16'd1;
                        end
                    end
                end
            end
            att_pkg::ST_AGE: begin
                age = cur_reg.now_ms - first_reg[idx_reg];
                if (valid_reg[idx_reg] && !pol_reg[idx_reg] && age > window_ms &&
                    hits_reg[idx_reg] < {15'd0, thr}) begin
                    valid_next[idx_reg] = 1'b0;
                end
                idx_next = idx_reg + W'(1);
                if (idx_reg == W'(N - 1)) begin
                    state_next = cfg_escalate ? att_pkg::ST_ESC : att_pkg::ST_IDLE;
                end
            end
            att_pkg::ST_ESC: begin
                // Hold while an earlier escalation still waits to be taken.
                if (!esc_vec[idx_reg] || !o_valid_reg || m_ready) begin
                    if (esc_vec[idx_reg]) begin
                        tbl_act_we = 1'b1; tbl_act = att_pkg::ACT_REDIRECT_MIRROR;
                        o_kind_next = att_pkg::KIND_ESC; o_slot_next = 6'(idx_reg);
                        o_addr_next = addr_reg[idx_reg]; o_hits_next = hits_reg[idx_reg];
                        o_act_next = att_pkg::ACT_REDIRECT_MIRROR;
                        o_last_next = !esc_more; o_valid_next = 1'b1;
                    end
                    idx_next = idx_reg + W'(1);
                    if (idx_reg == W'(N - 1)) state_next = att_pkg::ST_IDLE;
                end
            end
            default: state_next = att_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            hits_reg[tbl_idx] <= tbl_hits;
            if (tbl_claim) begin
                addr_reg[tbl_idx]  <= cur_reg.addr;
                first_reg[tbl_idx] <= cur_reg.now_ms;
            end
        end
        if (tbl_claim || tbl_pol_we) pol_reg[tbl_idx] <= tbl_pol_we;
        if (tbl_claim || tbl_act_we) begin
            act_reg[tbl_idx] <= tbl_act_we ? tbl_act : att_pkg::ACT_REDIRECT;
        end
        cur_reg <= cur_next; idx_reg <= idx_next;
        o_kind_reg <= o_kind_next; o_act_reg <= o_act_next; o_slot_reg <= o_slot_next;
        o_addr_reg <= o_addr_next; o_hits_reg <= o_hits_next; o_last_reg <= o_last_next;
        if (!aresetn) begin
            state_reg <= att_pkg::ST_IDLE; valid_reg <= '0; made_reg <= '0;
            last_eval_reg <= '0; o_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next; valid_reg <= valid_next; made_reg <= made_next;
            last_eval_reg <= last_eval_next; o_valid_reg <= o_valid_next;
        end
    end

    assign m_valid    = o_valid_reg;
    assign m_kind     = o_kind_reg;
    assign m_slot     = o_slot_reg;
    assign m_addr_out = o_addr_reg;
    assign m_action   = o_act_reg;
    assign m_hits     = o_hits_reg;
    assign m_last     = o_last_reg;
endmodule

>>> design/att_cfg.sv
// APB-style register file for the tracker settings.
module att_cfg (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic        cfg_enable,
    output logic [15:0] cfg_thresh,
    output logic [15:0] cfg_window,
    output logic [15:0] cfg_cap,
    output logic [1:0]  cfg_first_action,
    output logic        cfg_escalate
);
    logic        we;
    logic [2:0]  ri;
    logic [31:0] ttl_reg;
    assign pready = 1'b1;
    assign we = psel && penable && pwrite;
    assign ri = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_enable <= 1'b1; cfg_thresh <= 16'd5; cfg_window <= 16'd300;
            ttl_reg <= 32'd3600; cfg_cap <= 16'd256; cfg_first_action <= 2'd0;
            cfg_escalate <= 1'b1;
        end else if (we) begin
            case (ri)
                att_pkg::REG_ENABLE:   cfg_enable <= pwdata[0];
                att_pkg::REG_THRESH:   cfg_thresh <= pwdata[15:0];
                att_pkg::REG_WINDOW:   cfg_window <= pwdata[15:0];
                att_pkg::REG_TTL:      ttl_reg <= pwdata;
                att_pkg::REG_CAP:      cfg_cap <= pwdata[15:0];
                att_pkg::REG_FIRSTACT: cfg_first_action <= pwdata[1:0];
                att_pkg::REG_ESCALATE: cfg_escalate <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (ri)
            att_pkg::REG_ENABLE:   prdata = {31'd0, cfg_enable};
            att_pkg::REG_THRESH:   prdata = {16'd0, cfg_thresh};
            att_pkg::REG_WINDOW:   prdata = {16'd0, cfg_window};
            att_pkg::REG_TTL:      prdata = ttl_reg;
            att_pkg::REG_CAP:      prdata = {16'd0, cfg_cap};
            att_pkg::REG_FIRSTACT: prdata = {30'd0, cfg_first_action};
            att_pkg::REG_ESCALATE: prdata = {31'd0, cfg_escalate};
            default:               prdata = 32'd0;
        endcase
    end
endmodule

>>> design/attacker_threshold_tracker_unit.sv
// Top level of the attacker threshold tracker.
// An attack event is popped from the queue into the current-request register; table
// match, update and output register load follow, held while the output is full. The
// single engine that owns the table handles one attack event at a time. An evaluation
// tick ages all trackers, then, if enabled, runs the escalation scan, which can stall.
// Reset (aresetn low, synchronous) clears all trackers, counters and queue.
module attacker_threshold_tracker_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [31:0] s_source_addr,
    input  logic [47:0] s_now_ms,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [5:0]  m_slot,
    output logic [31:0] m_addr_out,
    output logic [1:0]  m_action,
    output logic [31:0] m_hits,
    output logic        m_last
);
    logic        cfg_enable, cfg_escalate;
    logic [15:0] cfg_thresh, cfg_window, cfg_cap;
    logic [1:0]  cfg_first_action;
    logic        q_valid, q_ready;
    att_pkg::req_t s_req, q_req;

    assign s_req.cmd    = s_cmd;
    assign s_req.addr   = s_source_addr;
    assign s_req.now_ms = s_now_ms;

    // Settings registers; the TTL is kept for readback only.
    att_cfg u_cfg (
        .aclk, .aresetn, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .cfg_enable, .cfg_thresh, .cfg_window, .cfg_cap,
        .cfg_first_action, .cfg_escalate
    );

    // Accept requests into a two-entry queue.
    att_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_req, .q_valid, .q_ready, .q_req
    );

    // Match, count, age and escalate.
    att_back u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_req,
        .cfg_enable, .cfg_thresh, .cfg_window, .cfg_cap, .cfg_first_action,
        .cfg_escalate,
        .m_valid, .m_ready, .m_kind, .m_slot, .m_addr_out, .m_action, .m_hits, .m_last
    );
endmodule
